// ===== design/ptm_pkg.sv =====
// Shared types, codes and constants of the PCM track mixer.
`default_nettype none

package ptm_pkg;

	// Stream widths
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 32;
	localparam int CFG_DATA_W  = 11;

	// Item kinds carried in s_tuser
	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_FRAME = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	// Configuration register indexes
	localparam logic CFG_DEVICE_STEREO = 1'b0;
	localparam logic CFG_BUFFER_FRAMES = 1'b1;

	// Commands from front to back
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_ADD   = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// Sample clamp limits
	localparam logic signed [16:0] AMP_MIN = -17'sd32765;
	localparam logic signed [16:0] AMP_MAX = 17'sd32765;

	typedef struct packed {
		logic        device_stereo;
		logic [10:0] buffer_frames;
	} ptm_cfg_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [15:0] amp_l;
		logic signed [15:0] amp_r;
		logic [3:0]         rep_n;
		logic [9:0]         read_index;
	} ptm_cmd_t;

endpackage

`default_nettype wire

// ===== design/ptm_front.sv =====
// Front end: takes items, tracks gain and decimation, scales samples, issues commands.
`default_nettype none

module ptm_front import ptm_pkg::*; #(
	parameter int MAX_REPEAT = 8,
	parameter int MAX_SKIP   = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ptm_cfg_t              cfg,
	input  logic                  clearing,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [1:0]            s_tuser,
	input  logic [IN_TDATA_W-1:0] s_tdata,
	output logic                  cmd_valid,
	input  logic                  cmd_ready,
	output ptm_cmd_t              cmd
);

	// stage 1: accepted item
	logic               v_s1;
	logic [1:0]         mode_s1;
	logic [15:0]        prod_s1;
	logic               stereo_s1;
	logic [4:0]         sstep_s1;
	logic [3:0]         rstep_s1;
	logic signed [15:0] left_s1;
	logic signed [15:0] right_s1;
	logic [9:0]         ridx_s1;

	// track state
	logic [7:0] gain_q;
	logic       stereo_q;
	logic [4:0] sstep_q;
	logic [4:0] skip_q;

	// stage 2: command being built
	logic               v_s2;
	logic [1:0]         kind_s2;
	logic               stereo_s2;
	logic signed [24:0] pl_s2;
	logic signed [24:0] pr_s2;
	logic [3:0]         rep_s2;
	logic [9:0]         ridx_s2;

	logic               s_fire;
	logic               s2_free;
	logic               s1_fire;
	logic               fwd_s1;
	logic [1:0]         kind_c;
	logic [16:0]        gp1_c;
	logic [24:0]        gw_c;
	logic [7:0]         gain_c;
	logic [4:0]         sstep_c;
	logic [3:0]         rstep_c;
	logic               keep_c;
	logic [4:0]         skip_inc_c;
	logic signed [24:0] pl_c;
	logic signed [24:0] pr_c;

	assign s2_free  = !v_s2 || cmd_ready;
	assign s1_fire  = v_s1 && s2_free;
	assign s_tready = (!v_s1 || s2_free) && !clearing;
	assign s_fire   = s_tvalid && s_tready;

	// floor(p/255) = ((p+1)*257) >> 16 for 16-bit p
	assign gp1_c  = {1'b0, prod_s1} + 17'd1;
	assign gw_c   = {gp1_c, 8'b0} + {8'b0, gp1_c};
	assign gain_c = gw_c[23:16];

	always_comb begin
		priority if (sstep_s1 == 5'd0) begin
			sstep_c = 5'd1;
		end else if (int'(sstep_s1) > MAX_SKIP) begin
			sstep_c = 5'(MAX_SKIP);
		end else begin
			sstep_c = sstep_s1;
		end
	end

	always_comb begin
		priority if (rstep_s1 == 4'd0) begin
			rstep_c = 4'd1;
		end else if (int'(rstep_s1) > MAX_REPEAT) begin
			rstep_c = 4'(MAX_REPEAT);
		end else begin
			rstep_c = rstep_s1;
		end
	end

	assign keep_c     = (skip_q == 5'd0);
	assign skip_inc_c = skip_q + 5'd1;

	assign pl_c = left_s1 * $signed({1'b0, gain_q});
	assign pr_c = right_s1 * $signed({1'b0, gain_q});

	always_comb begin
		unique case (mode_s1)
			MODE_START: begin
				fwd_s1 = 1'b1;
				kind_c = CMD_START;
			end
			MODE_FRAME: begin
				fwd_s1 = keep_c && (gain_q != 8'd0);
				kind_c = CMD_ADD;
			end
			MODE_READ: begin
				fwd_s1 = 1'b1;
				kind_c = CMD_READ;
			end
			default: begin
				fwd_s1 = 1'b0;
				kind_c = CMD_READ;
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			gain_q   <= 8'd0;
			stereo_q <= 1'b0;
			sstep_q  <= 5'd1;
			skip_q   <= 5'd0;
		end else begin
			if (s_fire) begin
				v_s1 <= 1'b1;
			end else if (s1_fire) begin
				v_s1 <= 1'b0;
			end
			if (s1_fire && fwd_s1) begin
				v_s2 <= 1'b1;
			end else if (cmd_ready) begin
				v_s2 <= 1'b0;
			end
			if (s1_fire && mode_s1 == MODE_START) begin
				gain_q   <= gain_c;
				stereo_q <= stereo_s1;
				sstep_q  <= sstep_c;
				skip_q   <= 5'd0;
			end else if (s1_fire && mode_s1 == MODE_FRAME) begin
				skip_q <= (skip_inc_c >= sstep_q) ? 5'd0 : skip_inc_c;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (s_fire) begin
			mode_s1   <= s_tuser;
			prod_s1   <= s_tdata[7:0] * s_tdata[15:8];
			stereo_s1 <= s_tdata[16];
			sstep_s1  <= s_tdata[21:17];
			rstep_s1  <= s_tdata[25:22];
			left_s1   <= s_tdata[41:26];
			right_s1  <= s_tdata[57:42];
			ridx_s1   <= s_tdata[67:58];
		end
		if (s1_fire && fwd_s1) begin
			kind_s2   <= kind_c;
			stereo_s2 <= stereo_q;
			pl_s2     <= pl_c;
			pr_s2     <= pr_c;
			rep_s2    <= rstep_c;
			ridx_s2   <= ridx_s1;
		end
	end

	// floor shift and channel routing
	logic signed [24:0] sh_l;
	logic signed [24:0] sh_r;
	logic signed [15:0] al;
	logic signed [15:0] ar;
	logic signed [16:0] sum_c;
	logic signed [16:0] adj_c;

	assign sh_l  = pl_s2 >>> 8;
	assign sh_r  = pr_s2 >>> 8;
	assign al    = sh_l[15:0];
	assign ar    = sh_r[15:0];
	assign sum_c = {al[15], al} + {ar[15], ar};
	assign adj_c = sum_c + {16'b0, sum_c[16]};

	always_comb begin
		cmd.kind       = kind_s2;
		cmd.rep_n      = rep_s2;
		cmd.read_index = ridx_s2;
		if (stereo_s2) begin
			cmd.amp_l = cfg.device_stereo ? al : adj_c[16:1];
			cmd.amp_r = ar;
		end else begin
			cmd.amp_l = al;
			cmd.amp_r = al;
		end
	end

	assign cmd_valid = v_s2;

endmodule

`default_nettype wire

// ===== design/ptm_queue.sv =====
// Short command queue between front and back.
`default_nettype none

module ptm_queue import ptm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  ptm_cmd_t push_data,
	output logic     pop_valid,
	input  logic     pop_ready,
	output ptm_cmd_t pop_data
);

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	ptm_cmd_t          entries_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     cnt_q;
	logic              push;
	logic              pop;

	assign push_ready = (cnt_q != CW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = entries_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== design/ptm_back.sv =====
// Back end: mix store, clearing pass, read-modify-write of frames, read-out register.
`default_nettype none

module ptm_back import ptm_pkg::*; #(
	parameter int BUF_FRAMES = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ptm_cfg_t               cfg,
	output logic                   clearing,
	input  logic                   cmd_valid,
	output logic                   cmd_ready,
	input  ptm_cmd_t               cmd,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int AW  = $clog2(BUF_FRAMES);
	localparam int NW  = $clog2(BUF_FRAMES + 1);
	localparam int XW  = (NW > 11) ? NW : 11;

	localparam logic [2:0] ST_CLEAR   = 3'd0;
	localparam logic [2:0] ST_IDLE    = 3'd1;
	localparam logic [2:0] ST_ADD_RD  = 3'd2;
	localparam logic [2:0] ST_ADD_WR  = 3'd3;
	localparam logic [2:0] ST_READ_RD = 3'd4;
	localparam logic [2:0] ST_READ_WR = 3'd5;

	function automatic logic signed [15:0] sat_add(
		input logic signed [15:0] a,
		input logic signed [15:0] b
	);
		logic signed [16:0] s;
		s = {a[15], a} + {b[15], b};
		priority if (s < AMP_MIN) begin
			return AMP_MIN[15:0];
		end else if (s > AMP_MAX) begin
			return AMP_MAX[15:0];
		end else begin
			return s[15:0];
		end
	endfunction

	logic [31:0]        store [BUF_FRAMES];
	logic [31:0]        rdata_q;

	logic [2:0]         st_q;
	logic [AW-1:0]      clr_q;
	logic [XW-1:0]      wp_q;
	logic [3:0]         rep_q;
	logic [3:0]         cnt_q;
	logic               out_v_q;
	logic signed [15:0] amp_l_q;
	logic signed [15:0] amp_r_q;
	logic [9:0]         idx_q;
	logic [15:0]        out_l_q;
	logic [15:0]        out_r_q;

	logic [XW-1:0]      bf_x;
	logic [XW-1:0]      len_c;
	logic [XW-1:0]      idx_x;
	logic               idx_ok;
	logic               add_done;
	logic               slot_free;
	logic signed [15:0] new_l;
	logic signed [15:0] new_r;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [31:0]        mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;

	assign bf_x      = XW'(cfg.buffer_frames);
	assign len_c     = (bf_x < XW'(BUF_FRAMES)) ? bf_x : XW'(BUF_FRAMES);
	assign idx_x     = XW'(idx_q);
	assign idx_ok    = (idx_x < XW'(BUF_FRAMES));
	assign add_done  = (wp_q >= len_c) || (cnt_q == rep_q);
	assign slot_free = !out_v_q || m_tready;
	assign new_l     = sat_add(rdata_q[15:0], amp_l_q);
	assign new_r     = cfg.device_stereo ? sat_add(rdata_q[31:16], amp_r_q) : rdata_q[31:16];

	assign clearing  = (st_q == ST_CLEAR);
	assign cmd_ready = (st_q == ST_IDLE);
	assign m_tvalid  = out_v_q;
	assign m_tdata   = {out_r_q, out_l_q};

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (st_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			ST_ADD_RD: begin
				mem_re    = !add_done;
				mem_raddr = wp_q[AW-1:0];
			end
			ST_ADD_WR: begin
				mem_we    = 1'b1;
				mem_waddr = wp_q[AW-1:0];
				mem_wdata = {new_r, new_l};
			end
			ST_READ_RD: begin
				mem_re    = slot_free && idx_ok;
				mem_raddr = idx_x[AW-1:0];
			end
			ST_READ_WR: begin
				mem_we    = idx_ok;
				mem_waddr = idx_x[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rdata_q <= store[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_CLEAR;
			clr_q   <= '0;
			wp_q    <= '0;
			rep_q   <= 4'd1;
			cnt_q   <= 4'd0;
			out_v_q <= 1'b0;
		end else begin
			if (st_q == ST_READ_WR) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			unique case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(BUF_FRAMES - 1)) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd.kind)
							CMD_START: begin
								wp_q  <= '0;
								rep_q <= cmd.rep_n;
							end
							CMD_ADD: begin
								cnt_q <= 4'd0;
								st_q  <= ST_ADD_RD;
							end
							CMD_READ: begin
								st_q <= ST_READ_RD;
							end
							default: begin
							end
						endcase
					end
				end
				ST_ADD_RD: begin
					st_q <= add_done ? ST_IDLE : ST_ADD_WR;
				end
				ST_ADD_WR: begin
					wp_q  <= wp_q + 1'b1;
					cnt_q <= cnt_q + 4'd1;
					st_q  <= ST_ADD_RD;
				end
				ST_READ_RD: begin
					if (slot_free) begin
						st_q <= ST_READ_WR;
					end
				end
				ST_READ_WR: begin
					st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && cmd_valid) begin
			amp_l_q <= cmd.amp_l;
			amp_r_q <= cmd.amp_r;
			idx_q   <= cmd.read_index;
		end
		if (st_q == ST_READ_WR) begin
			out_l_q <= idx_ok ? rdata_q[15:0] : 16'd0;
			out_r_q <= idx_ok ? rdata_q[31:16] : 16'd0;
		end
	end

endmodule

`default_nettype wire

// ===== design/pcm_track_mixer_core.sv =====
// Top level of the PCM track mixer: configuration registers and front/queue/back wiring.
//
// Mixes 16-bit PCM tracks, one at a time, into a store of BUF_FRAMES stereo frames.
// Input stream (s_*): s_tuser carries the item kind (start track, source frame,
// read-and-clear). A start track latches gain floor(tv*sv/255), source mode and
// steps and rewinds the write position; kept source frames are scaled and added,
// clamped to +/-32765, into repeat_step consecutive frames. Output stream (m_*)
// carries one transaction per read item: the stored frame, which is then zeroed.
// Config port: the user writes cfg_we/cfg_index/cfg_data only while the block is idle.
// Pipeline: the front registers each item on acceptance and again once scaled, then the
// 2-entry command queue. The back takes a start while idle, adds a frame by a read state
// and a write state per destination frame, and serves a read by a read state that waits
// for a free output slot and a write state that fills it. Items are accepted
// one per cycle while the queue has room and no clearing runs, so the back sets the rate.
// Reset: asynchronous, active low. Then the back zeroes all BUF_FRAMES store frames with
// s_tready low; config writes are still taken, as the block does not enforce idle.
// Receiver stall: the result sits in the output register and the back stalls at the next
// read; the front keeps accepting until the queue fills, then s_tready drops.
`default_nettype none

module pcm_track_mixer_core import ptm_pkg::*; #(
	parameter int BUF_FRAMES = 1024,
	parameter int MAX_REPEAT = 8,
	parameter int MAX_SKIP   = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// input stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [1:0]             s_tuser,  // mode
	// track_volume[7:0], sound_volume[15:8], source_stereo[16], source_step[21:17],
	// repeat_step[25:22], sample_left[41:26], sample_right[57:42], read_index[67:58]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// output stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata   // mixed_left[15:0], mixed_right[31:16]
);

	ptm_cfg_t cfg_q;
	logic     clearing;
	logic     f_valid;
	logic     f_ready;
	ptm_cmd_t f_cmd;
	logic     b_valid;
	logic     b_ready;
	ptm_cmd_t b_cmd;

	// config registers; reset to stereo device, full 1024-frame buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_stereo <= 1'b1;
			cfg_q.buffer_frames <= 11'd1024;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEVICE_STEREO: cfg_q.device_stereo <= cfg_data[0];
				CFG_BUFFER_FRAMES: cfg_q.buffer_frames <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// front: classify, gain, decimation, scaling
	ptm_front #(
		.MAX_REPEAT(MAX_REPEAT),
		.MAX_SKIP  (MAX_SKIP)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.clearing (clearing),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.cmd_valid(f_valid),
		.cmd_ready(f_ready),
		.cmd      (f_cmd)
	);

	// decouples front from the store's read-modify-write loop
	ptm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data (f_cmd),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_data  (b_cmd)
	);

	// back: mix store and result register
	ptm_back #(
		.BUF_FRAMES(BUF_FRAMES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.clearing (clearing),
		.cmd_valid(b_valid),
		.cmd_ready(b_ready),
		.cmd      (b_cmd),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

// ===== design/ptm_checker.sv =====
// Port-level checks of the PCM track mixer, bound to the top level.
`default_nettype none

module ptm_checker import ptm_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tvalid,
	input wire logic                   s_tready,
	input wire logic [1:0]             s_tuser,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata
);

	// reads accepted but not yet delivered
	logic [3:0] pend_q;
	logic       rd_in;
	logic       rd_out;

	assign rd_in  = s_tvalid && s_tready && (s_tuser == MODE_READ);
	assign rd_out = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 4'd0;
		end else if (rd_in && !rd_out) begin
			pend_q <= pend_q + 4'd1;
		end else if (rd_out && !rd_in) begin
			pend_q <= pend_q - 4'd1;
		end
	end

	a_no_unasked_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (pend_q != 4'd0))
		else $error("result transaction without an outstanding read");

	a_result_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[15:0]) >= AMP_MIN && $signed(m_tdata[15:0]) <= AMP_MAX
			&& $signed(m_tdata[31:16]) >= AMP_MIN && $signed(m_tdata[31:16]) <= AMP_MAX))
		else $error("mixed sample outside clamp range");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed or dropped");

endmodule

bind pcm_track_mixer_core ptm_checker u_ptm_checker (.*);

`default_nettype wire
